// ===== rtl/skp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Skyline rectangle packer package
// Shared field widths, codes, reset values and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package skp_pkg;

   // Field widths
   localparam int DIM_W      = 12;   // block width and height
   localparam int SKY_W      = 13;   // signed skyline entry and row values
   localparam int PWIDTH_W   = 11;   // page_width register
   localparam int PHEIGHT_W  = 12;   // page_height register
   localparam int POSX_W     = 10;
   localparam int POSY_W     = 12;
   localparam int AREA_W     = 24;
   localparam int CSR_DATA_W = 12;   // widest register

   // Operation codes
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Register indexes
   localparam logic CSR_PAGE_WIDTH  = 1'b0;
   localparam logic CSR_PAGE_HEIGHT = 1'b1;

   // Reset values of the registers
   localparam logic [PWIDTH_W-1:0]  PAGE_WIDTH_RST  = 11'd1024;
   localparam logic [PHEIGHT_W-1:0] PAGE_HEIGHT_RST = 12'd1024;

   // Skyline markers
   localparam logic signed [SKY_W-1:0] SKY_EMPTY = -13'sd1;
   localparam logic signed [SKY_W-1:0] SKY_NONE  = -13'sd2;

   localparam logic [AREA_W-1:0] AREA_MAX = 24'hFF_FFFF;

   // Read address select for the skyline memory
   typedef enum logic [1:0] {
      RD_X,
      RD_X_NEXT,
      RD_J_NEXT
   } skp_rd_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic           load_req;     // capture the request fields
      logic           clear_state;  // reset memo, used height and area
      skp_rd_sel_type rd_sel;
      logic           scan_init;    // start the window scan at column zero
      logic           skip_adv;     // skip one column equal to the last maximum
      logic           win_start;    // open a window at x
      logic           win_step;     // fold one more column into the window
      logic           win_end;      // close the window, keep the lowest maximum
      logic           memo_update;  // remember the failed size
      logic           commit;       // accept placement, form the area product
      logic           area_add;     // accumulate area, saturating
      logic           fill;         // write an empty entry, advance
      logic           wr_block;     // raise one covered column, advance
      logic           rsp_load;     // load the result registers
   } skp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic op_clear;
      logic w_zero;
      logic memo_hit;
      logic fits;
      logic skip_eq;
      logic w_one;
      logic win_last;
      logic found;
      logic too_tall;
      logic write_last;
      logic sweep_last;
   } skp_status_type;

endpackage
`default_nettype wire

// ===== rtl/skp_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Skyline packer datapath
// Registers, skyline memory, window scan arithmetic and result registers.
// ----------------------------------------------------------------------------
module skp_datapath import skp_pkg::*; #(
   parameter int MAX_COLUMNS = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic                     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                     req_operation,
   input  wire logic [DIM_W-1:0]         req_block_width,
   input  wire logic [DIM_W-1:0]         req_block_height,
   input  wire skp_cmd_type              cmd,
   output skp_status_type                status,
   output logic                          rsp_placed,
   output logic [POSX_W-1:0]             rsp_pos_x,
   output logic [POSY_W-1:0]             rsp_pos_y,
   output logic signed [SKY_W-1:0]       rsp_used_height,
   output logic [AREA_W-1:0]             rsp_area_used
);

   localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CW = $clog2(MAX_COLUMNS + 1);
   localparam int SW = ((CW > DIM_W) ? CW : DIM_W) + 1;
   localparam logic [SW-1:0] COL_LIMIT = SW'(MAX_COLUMNS);

   // Registers
   logic [PWIDTH_W-1:0]     page_width_ff;
   logic [PHEIGHT_W-1:0]    page_height_ff;
   logic [DIM_W-1:0]        bw_ff, bh_ff;
   logic [SKY_W-1:0]        reject_w_ff, reject_h_ff;
   logic signed [SKY_W-1:0] top_used_ff, top_used_in;
   logic [AREA_W-1:0]       area_ff;
   logic [CW-1:0]           x_ff, j_ff, idx_ff, best_x_ff;
   logic signed [SKY_W-1:0] best_ff, last_max_ff, min_y_ff;
   logic                    found_ff, placed_ff;
   logic [AREA_W-1:0]       prod_ff;
   logic [POSX_W-1:0]       px_ff;
   logic [POSY_W-1:0]       py_ff;
   logic signed [SKY_W-1:0] rd_data_ff;
   logic signed [SKY_W-1:0] sky_mem [MAX_COLUMNS];

   // Combinational terms
   logic [SW-1:0]           cols, x_end, write_end;
   logic [CW-1:0]           j_next, rd_addr;
   logic [AW-1:0]           rd_idx, wr_idx;
   logic                    mem_we;
   logic signed [SKY_W-1:0] mem_wdata, sky_new, y_pos, y_top;
   logic signed [14:0]      tall_lhs;
   logic [AREA_W:0]         area_sum;

   // Clamp page width to the skyline depth
   always_comb begin
      cols = SW'(page_width_ff);
      if (cols > COL_LIMIT) begin
         cols = COL_LIMIT;
      end
   end

   assign x_end     = SW'(x_ff) + SW'(bw_ff);
   assign write_end = SW'(best_x_ff) + SW'(bw_ff);
   assign j_next    = j_ff + CW'(1);

   // Placement arithmetic
   assign sky_new  = min_y_ff + $signed(SKY_W'(bh_ff));
   assign y_pos    = min_y_ff + 13'sd1;
   assign y_top    = y_pos + $signed(SKY_W'(bh_ff));
   assign tall_lhs = 15'(min_y_ff) + $signed(15'(bh_ff)) + 15'sd2;
   assign area_sum = (AREA_W+1)'(area_ff) + (AREA_W+1)'(prod_ff);

   always_comb begin
      top_used_in = top_used_ff;
      if (y_top > top_used_ff) begin
         top_used_in = y_top;
      end
   end

   // Status to the controller
   assign status.op_clear   = (req_operation == OP_CLEAR);
   assign status.w_zero     = (bw_ff == '0);
   assign status.memo_hit   = (SKY_W'(bw_ff) >= reject_w_ff) && (SKY_W'(bh_ff) >= reject_h_ff);
   assign status.fits       = (x_end <= cols);
   assign status.skip_eq    = (rd_data_ff == last_max_ff);
   assign status.w_one      = (bw_ff == DIM_W'(1));
   assign status.win_last   = (SW'(j_next) == x_end);
   assign status.found      = found_ff;
   assign status.too_tall   = (tall_lhs >= $signed(15'(page_height_ff)));
   assign status.write_last = (SW'(j_next) == write_end);
   assign status.sweep_last = (SW'(j_ff) == (COL_LIMIT - SW'(1)));

   // Skyline memory port selection
   always_comb begin
      unique case (cmd.rd_sel)
         RD_X:      rd_addr = x_ff;
         RD_X_NEXT: rd_addr = x_ff + CW'(1);
         RD_J_NEXT: rd_addr = j_next;
         default:   rd_addr = x_ff;
      endcase
   end

   assign rd_idx    = rd_addr[AW-1:0];
   assign wr_idx    = j_ff[AW-1:0];
   assign mem_we    = cmd.fill || cmd.wr_block;
   assign mem_wdata = cmd.fill ? SKY_EMPTY : sky_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sky_mem[wr_idx] <= mem_wdata;
      end
      rd_data_ff <= sky_mem[rd_idx];
   end

   // Registers, memo, used height, area and column counter
   always_ff @(posedge clock) begin
      if (reset) begin
         page_width_ff  <= PAGE_WIDTH_RST;
         page_height_ff <= PAGE_HEIGHT_RST;
         reject_w_ff    <= SKY_W'(PAGE_WIDTH_RST) + SKY_W'(1);
         reject_h_ff    <= SKY_W'(PAGE_HEIGHT_RST) + SKY_W'(1);
         top_used_ff    <= SKY_EMPTY;
         area_ff        <= '0;
         j_ff           <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_PAGE_WIDTH:  page_width_ff  <= csr_wdata[PWIDTH_W-1:0];
               CSR_PAGE_HEIGHT: page_height_ff <= csr_wdata[PHEIGHT_W-1:0];
               default:         page_width_ff  <= page_width_ff;
            endcase
         end
         if (cmd.clear_state) begin
            reject_w_ff <= SKY_W'(page_width_ff) + SKY_W'(1);
            reject_h_ff <= SKY_W'(page_height_ff) + SKY_W'(1);
            top_used_ff <= SKY_EMPTY;
            area_ff     <= '0;
         end
         if (cmd.memo_update) begin
            if ((SKY_W'(bw_ff) <= reject_w_ff) && (SKY_W'(bh_ff) <= reject_h_ff)) begin
               reject_w_ff <= SKY_W'(bw_ff);
               reject_h_ff <= SKY_W'(bh_ff);
            end
         end
         if (cmd.commit) begin
            top_used_ff <= top_used_in;
         end
         if (cmd.area_add) begin
            if (area_sum > (AREA_W+1)'(AREA_MAX)) begin
               area_ff <= AREA_MAX;
            end else begin
               area_ff <= area_sum[AREA_W-1:0];
            end
         end
         // column counter: sweeps, window columns and block writes
         priority if (cmd.load_req) begin
            j_ff <= '0;
         end else if (cmd.win_start) begin
            j_ff <= x_ff + CW'(1);
         end else if (cmd.commit) begin
            j_ff <= best_x_ff;
         end else if (cmd.fill || cmd.wr_block || cmd.win_step) begin
            j_ff <= j_next;
         end
      end
   end

   // Request capture, window scan, placement and result registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         bw_ff     <= req_block_width;
         bh_ff     <= req_block_height;
         placed_ff <= (req_operation == OP_CLEAR);
         px_ff     <= '0;
         py_ff     <= '0;
      end
      if (cmd.scan_init) begin
         x_ff        <= '0;
         last_max_ff <= SKY_NONE;
         min_y_ff    <= $signed(SKY_W'(page_height_ff));
         found_ff    <= 1'b0;
      end
      if (cmd.skip_adv) begin
         x_ff <= x_ff + CW'(1);
      end
      if (cmd.win_start) begin
         best_ff <= rd_data_ff;
         idx_ff  <= x_ff;
      end
      if (cmd.win_step) begin
         if (rd_data_ff >= best_ff) begin
            best_ff <= rd_data_ff;
            idx_ff  <= j_ff;
         end
      end
      if (cmd.win_end) begin
         last_max_ff <= best_ff;
         if (min_y_ff > best_ff) begin
            min_y_ff  <= best_ff;
            best_x_ff <= x_ff;
            found_ff  <= 1'b1;
         end
         x_ff <= idx_ff + CW'(1);
      end
      if (cmd.commit) begin
         prod_ff   <= AREA_W'(bw_ff) * AREA_W'(bh_ff);
         placed_ff <= 1'b1;
         px_ff     <= POSX_W'(best_x_ff);
         py_ff     <= y_pos[POSY_W-1:0];
      end
      if (cmd.rsp_load) begin
         rsp_placed      <= placed_ff;
         rsp_pos_x       <= px_ff;
         rsp_pos_y       <= py_ff;
         rsp_used_height <= top_used_ff;
         rsp_area_used   <= area_ff;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/skp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Skyline packer controller
// Sequences the clearing sweep, the window scan, the placement write and
// the result strobe.
// ----------------------------------------------------------------------------
module skp_ctrl import skp_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire skp_status_type status,
   output skp_cmd_type         cmd,
   output logic                busy,
   output logic                rsp_valid
);

   typedef enum logic [3:0] {
      ST_INIT_SWEEP,
      ST_IDLE,
      ST_CLEAR_SWEEP,
      ST_CHECK,
      ST_SKIP_RD,
      ST_SKIP_EV,
      ST_WIN,
      ST_WIN_END,
      ST_DECIDE,
      ST_ACCUM,
      ST_WRITE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = start && (state_ff == ST_IDLE);

   // Decode commands from the current state
   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RD_X;
      unique case (state_ff)
         ST_INIT_SWEEP: cmd.fill = 1'b1;
         ST_IDLE: begin
            cmd.load_req    = accept;
            cmd.clear_state = accept && status.op_clear;
         end
         ST_CLEAR_SWEEP: cmd.fill = 1'b1;
         ST_CHECK: cmd.scan_init = !status.w_zero && !status.memo_hit;
         ST_SKIP_RD: cmd.rd_sel = RD_X;
         ST_SKIP_EV: begin
            cmd.skip_adv  = status.skip_eq;
            cmd.win_start = !status.skip_eq;
            cmd.rd_sel    = RD_X_NEXT;
         end
         ST_WIN: begin
            cmd.win_step = 1'b1;
            cmd.rd_sel   = RD_J_NEXT;
         end
         ST_WIN_END: cmd.win_end = 1'b1;
         ST_DECIDE: begin
            cmd.memo_update = !status.found || status.too_tall;
            cmd.commit      = status.found && !status.too_tall;
         end
         ST_ACCUM:  cmd.area_add = 1'b1;
         ST_WRITE:  cmd.wr_block = 1'b1;
         ST_FINISH: cmd.rsp_load = 1'b1;
         default:   cmd = '0;
      endcase
   end

   // Hold state and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_INIT_SWEEP: begin
               if (status.sweep_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= status.op_clear ? ST_CLEAR_SWEEP : ST_CHECK;
               end
            end
            ST_CLEAR_SWEEP: begin
               if (status.sweep_last) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_CHECK: begin
               if (status.w_zero || status.memo_hit) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_SKIP_RD;
               end
            end
            ST_SKIP_RD: begin
               state_ff <= status.fits ? ST_SKIP_EV : ST_DECIDE;
            end
            ST_SKIP_EV: begin
               priority if (status.skip_eq) begin
                  state_ff <= ST_SKIP_RD;
               end else if (status.w_one) begin
                  state_ff <= ST_WIN_END;
               end else begin
                  state_ff <= ST_WIN;
               end
            end
            ST_WIN: begin
               if (status.win_last) begin
                  state_ff <= ST_WIN_END;
               end
            end
            ST_WIN_END: state_ff <= ST_SKIP_RD;
            ST_DECIDE: begin
               if (status.found && !status.too_tall) begin
                  state_ff <= ST_ACCUM;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_ACCUM: state_ff <= ST_WRITE;
            ST_WRITE: begin
               if (status.write_last) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== rtl/skyline_rectangle_packer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Skyline rectangle packer
// Bottom-left skyline placement of rectangles on a page, one request at a
// time, with a single result strobe per request.
// ----------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy is low; its result
// appears on the rsp_ ports for exactly one cycle with rsp_valid high, and
// must be captured then. After reset the block sweeps the skyline memory
// with busy high before it takes the first request; a clear request repeats
// that sweep. An add request reads the skyline window by window, skipping
// columns at the last window maximum, and on success writes the covered
// columns; an add refused at once for zero width or by the reject memo skips
// the scan. The single skyline memory, one column read or written per cycle,
// paces every request.
// Write the csr_ registers only while busy is low.
// ----------------------------------------------------------------------------
module skyline_rectangle_packer_top import skp_pkg::*; #(
   parameter int MAX_COLUMNS = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic                   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_operation,
   input  wire logic [DIM_W-1:0]       req_block_width,
   input  wire logic [DIM_W-1:0]       req_block_height,
   output logic                        rsp_valid,
   output logic                        rsp_placed,
   output logic [POSX_W-1:0]           rsp_pos_x,
   output logic [POSY_W-1:0]           rsp_pos_y,
   output logic signed [SKY_W-1:0]     rsp_used_height,
   output logic [AREA_W-1:0]           rsp_area_used
);

   skp_cmd_type    cmd;
   skp_status_type status;

   // Sequence control
   skp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Storage and arithmetic
   skp_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_operation    (req_operation),
      .req_block_width  (req_block_width),
      .req_block_height (req_block_height),
      .cmd              (cmd),
      .status           (status),
      .rsp_placed       (rsp_placed),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_used_height  (rsp_used_height),
      .rsp_area_used    (rsp_area_used)
   );

endmodule
`default_nettype wire

// ===== rtl/skp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Skyline packer port checker
// Watches the top level ports for request and result sequencing.
// ----------------------------------------------------------------------------
module skp_checker import skp_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_placed,
   input wire logic [POSX_W-1:0]      rsp_pos_x,
   input wire logic [POSY_W-1:0]      rsp_pos_y
);

   // The skyline sweep after reset keeps requests off
   a_reset_sweep: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   // A transfer in makes the block busy until its result
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // Results come one at a time, never on back-to-back cycles
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // The result is shown when the block returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // A refused block reports no position
   a_refused_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_placed) |-> ((rsp_pos_x == '0) && (rsp_pos_y == '0)))
      else $error("refused block with nonzero position");

endmodule

bind skyline_rectangle_packer_top skp_checker u_skp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_placed(rsp_placed),
   .rsp_pos_x (rsp_pos_x),
   .rsp_pos_y (rsp_pos_y)
);
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skyline rectangle packer testbench
// Drives add and clear requests through the start/busy handshake under a
// range of page sizes, predicts every placement with an in-bench skyline
// model and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module tb import skp_pkg::*;;

   localparam int COLUMNS   = 1024;
   localparam int RUN_LIMIT = 400_000_000;
   localparam int N_PHASES  = 9;

   typedef struct {
      logic             op;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
   } block_req_type;

   typedef struct {
      logic                    placed;
      logic [POSX_W-1:0]       x;
      logic [POSY_W-1:0]       y;
      logic signed [SKY_W-1:0] used;
      logic [AREA_W-1:0]       area;
   } placement_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic                  csr_index = CSR_PAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_operation = OP_ADD;
   logic [DIM_W-1:0]      req_block_width = '0;
   logic [DIM_W-1:0]      req_block_height = '0;
   logic                  rsp_valid;
   logic                  rsp_placed;
   logic [POSX_W-1:0]     rsp_pos_x;
   logic [POSY_W-1:0]     rsp_pos_y;
   logic signed [SKY_W-1:0] rsp_used_height;
   logic [AREA_W-1:0]     rsp_area_used;

   // Page model: registers and packing state
   logic [PWIDTH_W-1:0]     page_cols_reg;
   logic [PHEIGHT_W-1:0]    page_rows_reg;
   logic signed [SKY_W-1:0] sky_top [COLUMNS];
   logic [SKY_W-1:0]        memo_w;
   logic [SKY_W-1:0]        memo_h;
   logic signed [SKY_W-1:0] top_row;
   logic [AREA_W-1:0]       area_sum;

   block_req_type pending_blocks[$];
   placement_type expected_placements[$];
   placement_type oldest_placement;
   block_req_type next_block;

   int  queued_total = 0;
   int  results_seen = 0;
   int  error_count = 0;
   int  gap_left = 0;
   logic took = 1'b0;
   logic idle_on = 1'b1;

   int phase_cols [N_PHASES] = '{16, 1, 4095, 0, 64, 1024, 5, 0, 40};
   int phase_rows [N_PHASES] = '{64, 4095, 1, 0, 300, 4095, 30, 0, 200};
   int phase_items [N_PHASES] = '{40, 25, 15, 10, 35, 20, 40, 40, 45};

   skyline_rectangle_packer_top #(
      .MAX_COLUMNS(COLUMNS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_block_width(req_block_width),
      .req_block_height(req_block_height),
      .rsp_valid(rsp_valid),
      .rsp_placed(rsp_placed),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_used_height(rsp_used_height),
      .rsp_area_used(rsp_area_used)
   );

   always #10 clock = ~clock;

   // Empty the page and rearm the reject memo from the live registers
   function automatic void clear_page_model();
      for (int i = 0; i < COLUMNS; i++)
         sky_top[i] = SKY_EMPTY;
      memo_w   = SKY_W'(page_cols_reg) + SKY_W'(1);
      memo_h   = SKY_W'(page_rows_reg) + SKY_W'(1);
      top_row  = SKY_EMPTY;
      area_sum = '0;
   endfunction

   // Place one block on the model page and return the result it produces
   function automatic placement_type predict_placement(block_req_type r);
      placement_type res;
      int cols, w, h, rows, best_x, min_y, last_x, last_max, x, k, mi, top, y, a;
      res.placed = 1'b0;
      res.x = '0;
      res.y = '0;
      cols = (page_cols_reg > COLUMNS) ? COLUMNS : page_cols_reg;
      w = r.w;
      h = r.h;
      rows = page_rows_reg;
      if (r.op == OP_CLEAR) begin
         clear_page_model();
         res.placed = 1'b1;
      end else if (w == 0) begin
         // refuse without touching the memo
      end else if (w >= memo_w && h >= memo_h) begin
         // known to fail, leave everything as is
      end else begin
         best_x = -1;
         min_y = rows;
         last_x = cols - w;
         last_max = SKY_NONE;
         x = 0;
         // scan windows left to right, skip columns at the last window maximum
         while (x <= last_x) begin
            if (sky_top[x] == last_max) begin
               x++;
            end else begin
               mi = x;
               top = -1;
               for (k = x; k < x + w; k++) begin
                  if (sky_top[k] >= top) begin
                     top = sky_top[k];
                     mi = k;
                  end
               end
               last_max = sky_top[mi];
               if (min_y > last_max) begin
                  min_y = last_max;
                  best_x = x;
               end
               x = mi + 1;
            end
         end
         y = min_y + 1;
         if (best_x < 0 || y + h >= rows - 1) begin
            if (w <= memo_w && h <= memo_h) begin
               memo_w = SKY_W'(w);
               memo_h = SKY_W'(h);
            end
         end else begin
            if (y + h > top_row)
               top_row = SKY_W'(y + h);
            for (k = best_x; k < best_x + w; k++)
               sky_top[k] = SKY_W'(min_y + h);
            a = w * h;
            if (a > AREA_MAX - area_sum)
               area_sum = AREA_MAX;
            else
               area_sum = area_sum + AREA_W'(a);
            res.placed = 1'b1;
            res.x = POSX_W'(best_x);
            res.y = POSY_W'(y);
         end
      end
      res.used = top_row;
      res.area = area_sum;
      return res;
   endfunction

   // Driver: hold each request until taken, then idle or issue the next
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start && !took) begin
         // hold until the block takes the request
      end else if (gap_left != 0) begin
         start <= 1'b0;
         if (!busy)
            gap_left <= gap_left - 1;
      end else if (pending_blocks.size() != 0) begin
         next_block = pending_blocks.pop_front();
         req_operation <= next_block.op;
         req_block_width <= next_block.w;
         req_block_height <= next_block.h;
         start <= 1'b1;
         if (idle_on && $urandom_range(0, 2) == 0)
            gap_left <= $urandom_range(1, 5);
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: predict on each request transfer, check each result strobe
   always @(posedge clock) begin
      if (reset) begin
         took <= 1'b0;
      end else begin
         took <= start && !busy;
         if (rsp_valid) begin
            results_seen++;
            if (expected_placements.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: result with no request outstanding", $time);
            end else begin
               oldest_placement = expected_placements.pop_front();
               if (rsp_placed !== oldest_placement.placed
                   || rsp_pos_x !== oldest_placement.x
                   || rsp_pos_y !== oldest_placement.y
                   || rsp_used_height !== oldest_placement.used
                   || rsp_area_used !== oldest_placement.area) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $write("%0t: mismatch expected placed=%0d x=%0d y=%0d used=%0d area=%0d",
                            $time, oldest_placement.placed, oldest_placement.x,
                            oldest_placement.y, oldest_placement.used,
                            oldest_placement.area);
                     $display(", got placed=%0d x=%0d y=%0d used=%0d area=%0d",
                              rsp_placed, rsp_pos_x, rsp_pos_y,
                              rsp_used_height, rsp_area_used);
                  end
               end
            end
         end
         if (start && !busy)
            expected_placements.push_back(predict_placement(
               '{op: req_operation, w: req_block_width, h: req_block_height}));
      end
   end

   task automatic add_item(input logic op, input int w, input int h);
      pending_blocks.push_back('{op: op, w: DIM_W'(w), h: DIM_W'(h)});
      queued_total++;
   endtask

   // Wait until every queued request has its result and the block is idle
   task automatic wait_idle();
      while (results_seen < queued_total || busy)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write both page registers and mirror them in the model
   task automatic write_page(input int cols_val, input int rows_val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PAGE_WIDTH;
      csr_wdata <= CSR_DATA_W'(cols_val);
      page_cols_reg = PWIDTH_W'(cols_val);
      @(negedge clock);
      csr_index <= CSR_PAGE_HEIGHT;
      csr_wdata <= CSR_DATA_W'(rows_val);
      page_rows_reg = PHEIGHT_W'(rows_val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int p, cols, rows, pick, wmax, hmax;
      page_cols_reg = PAGE_WIDTH_RST;
      page_rows_reg = PAGE_HEIGHT_RST;
      clear_page_model();
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed requests on the reset page size
      add_item(OP_ADD, 0, 0);          // zero width
      add_item(OP_ADD, 0, 4095);
      add_item(OP_ADD, 1024, 1);       // full page width
      add_item(OP_ADD, 1, 0);          // zero height
      add_item(OP_ADD, 1025, 3);       // wider than the page, memo shrinks
      add_item(OP_ADD, 4095, 4095);    // memo rejection
      add_item(OP_ADD, 1025, 2);
      add_item(OP_ADD, 1, 1022);       // reaches the height limit
      add_item(OP_ADD, 1, 1021);
      add_item(OP_ADD, 3, 5);
      add_item(OP_ADD, 2, 5);
      add_item(OP_ADD, 1, 5);
      add_item(OP_ADD, 4095, 0);
      add_item(OP_CLEAR, 4095, 4095);
      add_item(OP_ADD, 512, 100);
      add_item(OP_ADD, 512, 200);
      add_item(OP_ADD, 600, 10);
      add_item(OP_ADD, 1, 1);
      add_item(OP_CLEAR, 0, 0);
      add_item(OP_ADD, 7, 4095);

      phase_cols[7] = $urandom_range(1, 100);
      phase_rows[7] = $urandom_range(8, 600);

      // Random phases, each on its own page size
      for (p = 0; p < N_PHASES; p++) begin
         wait_idle();
         write_page(phase_cols[p], phase_rows[p]);
         idle_on = (p != N_PHASES - 1) && (p % 3 != 2);
         cols = page_cols_reg > COLUMNS ? COLUMNS : page_cols_reg;
         rows = page_rows_reg;
         wmax = cols < 48 ? cols : cols / 8;
         if (wmax < 1)
            wmax = 1;
         hmax = rows / 4 + 1;
         if (p % 2 == 0)
            add_item(OP_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095));
         repeat (phase_items[p]) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               add_item(OP_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095));
            else if (pick == 1)
               add_item(OP_ADD, $urandom_range(0, 4095), $urandom_range(0, 4095));
            else
               add_item(OP_ADD, $urandom_range(1, wmax), $urandom_range(0, hmax));
         end
      end

      // Drain, let the block settle, then report
      wait_idle();
      repeat (10) @(negedge clock);
      error_count += expected_placements.size();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Give up if the block hangs
   initial begin
      #(RUN_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
